// File: rtl/ic_pkg.sv
// Shared types and constants for the inversion counter
`default_nettype none

package ic_pkg;

    // default sizing
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_BITS_DEF   = 32;

    // field widths on the ports
    localparam int VALUE_W    = 32;
    localparam int GB_W       = 6;
    localparam int INV_W      = 11;
    localparam int TOTAL_W    = 12;
    localparam int SUM_W      = TOTAL_W + 1;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 1;

    // saturation limits
    localparam logic [SUM_W-1:0]   GB_MAX    = SUM_W'(63);
    localparam logic [TOTAL_W-1:0] INV_MAX   = TOTAL_W'(2047);
    localparam logic [SUM_W-1:0]   TOTAL_MAX = SUM_W'(4095);

    // control flags that travel with an item down the chain
    typedef struct packed {
        logic valid;
        logic last;
        logic ovf;
    } item_ctl_t;

endpackage

`default_nettype wire

// File: rtl/ic_cell.sv
// One cell of the chain: holds one stored key and counts greater keys for passing items
`default_nettype none

module ic_cell #(
    parameter int KEY_W    = 32,
    parameter int IDX_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      adv,
    input  wire ic_pkg::item_ctl_t   in_ctl,
    input  wire [KEY_W-1:0]          in_key,
    input  wire [IDX_W-1:0]          in_idx,
    input  wire [IDX_W-1:0]          in_cnt,
    output ic_pkg::item_ctl_t        out_ctl,
    output logic [KEY_W-1:0]         out_key,
    output logic [IDX_W-1:0]         out_idx,
    output logic [IDX_W-1:0]         out_cnt
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    ic_pkg::item_ctl_t  ctl_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   cnt_next;
    logic [KEY_W-1:0]   stored_reg;
    logic               is_greater;
    logic               write_en;

    // compare only against keys written earlier in this sequence
    always_comb begin
        is_greater = in_ctl.valid && !in_ctl.ovf && (MY_IDX < in_idx) &&
                     (stored_reg > in_key);
        cnt_next   = in_cnt + IDX_W'(is_greater);
        write_en   = adv && in_ctl.valid && !in_ctl.ovf && (in_idx == MY_IDX);
    end

    // item control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= in_ctl;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg <= in_key;
            idx_reg <= in_idx;
            cnt_reg <= cnt_next;
        end
    end

    // the key held by this cell
    always_ff @(posedge aclk) begin
        if (write_en) begin
            stored_reg <= in_key;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_key = key_reg;
    assign out_idx = idx_reg;
    assign out_cnt = cnt_reg;

endmodule

`default_nettype wire

// File: rtl/ic_tail.sv
// Chain tail: running total, saturation and the output register
`default_nettype none

module ic_tail #(
    parameter int IDX_W = 6
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire ic_pkg::item_ctl_t           in_ctl,
    input  wire [IDX_W-1:0]                  in_cnt,
    output logic                             adv,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [ic_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // greater_before, inversions, zero pad
    output logic                             m_axis_tlast,
    output logic [ic_pkg::M_TUSER_W-1:0]     m_axis_tuser   // overflow
);

    logic                          m_valid_reg;
    logic [ic_pkg::TOTAL_W-1:0]    total_reg;
    logic [ic_pkg::TOTAL_W-1:0]    total_next;
    logic [ic_pkg::TOTAL_W-1:0]    total_new;
    logic [ic_pkg::SUM_W-1:0]      cnt_ext;
    logic [ic_pkg::SUM_W-1:0]      sum;
    logic [ic_pkg::GB_W-1:0]       gb_reg;
    logic [ic_pkg::GB_W-1:0]       gb_next;
    logic [ic_pkg::INV_W-1:0]      inv_reg;
    logic [ic_pkg::INV_W-1:0]      inv_next;
    logic                          last_reg;
    logic                          ovf_reg;

    // chain moves whenever the output register is free or being emptied
    assign adv = !m_valid_reg || m_axis_tready;

    // running total with saturation, cleared after the last item of a sequence
    always_comb begin
        cnt_ext = ic_pkg::SUM_W'(in_cnt);
        sum     = {1'b0, total_reg} + cnt_ext;
        if (in_ctl.ovf) begin
            total_new = total_reg;
        end else if (sum > ic_pkg::TOTAL_MAX) begin
            total_new = ic_pkg::TOTAL_MAX[ic_pkg::TOTAL_W-1:0];
        end else begin
            total_new = sum[ic_pkg::TOTAL_W-1:0];
        end
        total_next = in_ctl.last ? '0 : total_new;
    end

    // output field saturation
    always_comb begin
        if (in_ctl.ovf) begin
            gb_next = '0;
        end else if (cnt_ext > ic_pkg::GB_MAX) begin
            gb_next = ic_pkg::GB_MAX[ic_pkg::GB_W-1:0];
        end else begin
            gb_next = cnt_ext[ic_pkg::GB_W-1:0];
        end
        if (total_new > ic_pkg::INV_MAX) begin
            inv_next = ic_pkg::INV_MAX[ic_pkg::INV_W-1:0];
        end else begin
            inv_next = total_new[ic_pkg::INV_W-1:0];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else if (adv) begin
            m_valid_reg <= in_ctl.valid;
            if (in_ctl.valid) begin
                total_reg <= total_next;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (adv && in_ctl.valid) begin
            gb_reg   <= gb_next;
            inv_reg  <= inv_next;
            last_reg <= in_ctl.last;
            ovf_reg  <= in_ctl.ovf;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = ic_pkg::M_TDATA_W'({inv_reg, gb_reg});
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = ovf_reg;

    // total only grows within a sequence
    a_total_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_ctl.valid && !in_ctl.last) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased inside a sequence");

    // a sequence end clears the total
    a_total_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && in_ctl.valid && in_ctl.last) |=> (total_reg == '0))
        else $error("running total not cleared after last item");

endmodule

`default_nettype wire

// File: rtl/inversion_counter.sv
// Inversion counter top level: head counter, chain of compare cells and output tail
//
// Usage: values enter on the s_axis channel, one per item, with s_axis_tlast on
// the final value of a sequence. Each item yields one result on m_axis: the number
// of earlier values strictly greater than it, the running inversion total, tlast
// copied from the input and tuser set when the store was full and the value dropped.
// Each item walks a chain of MAX_ELEMENTS cells, one cell per cycle while the chain
// advances; the cell whose position equals the item's slot keeps its key, earlier
// cells add to its count, and the tail registers the result for m_axis. One item is
// taken every cycle unless the output stalls, the whole chain advancing in lockstep.
// When the receiver stalls, the output register holds its item and the chain
// freezes, so s_axis_tready drops in the same cycle; nothing is lost.
// Reset (aresetn low, synchronous) empties the chain, the output register, the
// slot counter and the total; stored keys need no clearing since a cell is only
// compared against after it was written in the current sequence.
`default_nettype none

module inversion_counter #(
    parameter int MAX_ELEMENTS = ic_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = ic_pkg::VALUE_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [ic_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // value
    input  wire                              s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [ic_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // greater_before, inversions, zero pad
    output logic                             m_axis_tlast,
    output logic [ic_pkg::M_TUSER_W-1:0]     m_axis_tuser   // overflow
);

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int KEY_W = VALUE_BITS;

    logic                adv;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                full;
    logic                accept;
    logic [KEY_W-1:0]    raw;
    logic [KEY_W-1:0]    key_in;

    ic_pkg::item_ctl_t   ctl_chain [0:MAX_ELEMENTS];
    logic [KEY_W-1:0]    key_chain [0:MAX_ELEMENTS];
    logic [IDX_W-1:0]    idx_chain [0:MAX_ELEMENTS];
    logic [IDX_W-1:0]    cnt_chain [0:MAX_ELEMENTS];

    // take the low value bits, widening with zeros where the key is wider
    if (VALUE_BITS <= ic_pkg::VALUE_W) begin : g_narrow
        assign raw = s_axis_tdata[KEY_W-1:0];
    end else begin : g_wide
        assign raw = {{(KEY_W - ic_pkg::VALUE_W){1'b0}}, s_axis_tdata};
    end

    // flip the sign bit so unsigned compare orders two's complement values
    assign key_in = raw ^ {1'b1, {(KEY_W-1){1'b0}}};

    // slot counter at the head of the chain
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign full          = (count_reg == CW'(MAX_ELEMENTS));

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (s_axis_tlast) begin
                count_next = '0;
            end else if (!full) begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // item entering the chain
    assign ctl_chain[0] = '{valid: s_axis_tvalid, last: s_axis_tlast, ovf: full};
    assign key_chain[0] = key_in;
    assign idx_chain[0] = count_reg[IDX_W-1:0];
    assign cnt_chain[0] = '0;

    // chain of compare cells
    for (genvar j = 0; j < MAX_ELEMENTS; j++) begin : g_cell
        ic_cell #(
            .KEY_W    (KEY_W),
            .IDX_W    (IDX_W),
            .CELL_IDX (j)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .in_ctl  (ctl_chain[j]),
            .in_key  (key_chain[j]),
            .in_idx  (idx_chain[j]),
            .in_cnt  (cnt_chain[j]),
            .out_ctl (ctl_chain[j+1]),
            .out_key (key_chain[j+1]),
            .out_idx (idx_chain[j+1]),
            .out_cnt (cnt_chain[j+1])
        );
    end

    // running total and output register
    ic_tail #(
        .IDX_W (IDX_W)
    ) u_tail (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_ctl        (ctl_chain[MAX_ELEMENTS]),
        .in_cnt        (cnt_chain[MAX_ELEMENTS]),
        .adv           (adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // slot counter never passes the store depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_ELEMENTS))
        else $error("slot counter beyond store depth");

    // last item restarts the slot counter
    a_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_axis_tlast) |=> (count_reg == '0))
        else $error("slot counter not cleared after last item");

    // a stored item takes exactly one slot
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_axis_tlast && !full) |=> (count_reg == CW'($past(count_reg) + CW'(1))))
        else $error("slot counter did not advance by one");

endmodule

`default_nettype wire
